[src/matrix_multiply_top_assert.svh]
// Assertion macros for the matrix multiply block.
// Both sample on clk_i and stand down while rst_ni is low.
`ifndef MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define MATRIX_MULTIPLY_TOP_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mm_pkg.sv]
package mm_pkg;

  localparam int MAX_DIM     = 16;
  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int CNT_W       = $clog2(MAX_DIM + 1);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LCNT_W      = $clog2(STORE_DEPTH + 1);

  localparam int VAL_W     = 16;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 40;
  localparam int COL_W     = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic KIND_B = 1'b0;
  localparam logic KIND_A = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                    kind;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] result_value;
    logic [COL_W-1:0]        column;
    logic                    row_last;
    logic                    matrix_last;
    logic                    error;
  } out_t;

  // Clamp a register value to 1..MAX_DIM; zero counts as one.
  function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

[src/matrix_multiply_top.sv]
// Fixed point matrix multiply R = A x B, Q8.8 elements, exact Q24.16 sums.
// Input channel (in_valid_i/in_ready_o/in_data_i): each word is a B element
// (kind 0, row-major) or an A element (kind 1, row-major). B is loaded first;
// a B word arriving after B is complete starts a fresh load.
// Output channel (out_valid_o/out_ready_i/out_data_o): after the last A element
// of a row, cols_b words follow, one per cycle when unstalled, tagged with
// column, row_last and matrix_last. An A word before B is complete yields one
// word with error set, valid the cycle after it is taken, and is otherwise dropped.
// Config channel (cfg_valid_i/cfg_index_i/cfg_data_i): always ready; any write
// to a listed register restarts the load of B and the A progress.
// A B word is stored as it is taken. An A word is worked off with one
// multiply-accumulate per cycle through the single read port of the
// accumulator memory and its two-stage read/multiply/write-back pipe; the last
// A word of a row is followed by the readout of the row, and no new input word
// is taken until the multiply pass and any readout are done.
// Reset clears all control state; the B store is left as is and the row
// accumulator reads as zero at the start of every row, so no clearing pass.
// A stalled receiver holds the output word and halts the readout; a new
// input word is taken only once the output register is free or being drained.
module matrix_multiply_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mm_pkg::in_t                    in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mm_pkg::out_t                   out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mm_pkg::CFG_W-1:0]       cfg_data_i
);
  import mm_pkg::*;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  nr_q, nk_q, nc_q;
  logic [LCNT_W-1:0] b_cnt_q;
  logic              b_ready_q;
  logic [DIM_W-1:0]  inner_q;
  logic [DIM_W-1:0]  row_q;
  logic [ADDR_W-1:0] base_q;

  logic signed [VAL_W-1:0] value_q;
  logic                    first_q;
  logic                    last_row_q;
  logic                    emit_q;
  logic [CNT_W-1:0]        j_q;
  logic [ADDR_W-1:0]       addr_q;

  logic signed [VAL_W-1:0] b_mem [STORE_DEPTH];
  logic signed [ACC_W-1:0] acc_mem [MAX_DIM];

  logic signed [VAL_W-1:0]  b_rd_q;
  logic signed [ACC_W-1:0]  acc_rd_q;
  logic [DIM_W-1:0]         col_q;
  logic                     s1_vld_q;
  logic                     rd_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_s2_q;
  logic [DIM_W-1:0]         s2_col_q;
  logic                     s2_vld_q;

  logic  out_valid_q;
  out_t  out_q;

  logic                    cfg_wr, cfg_hit;
  logic                    in_acc, b_acc, a_acc, err_acc;
  logic                    mac_issue, emit_issue, take, mac_last;
  logic                    inner_last, row_last_flag;
  logic [2*CNT_W-1:0]      b_total;
  logic [LCNT_W-1:0]       b_idx;
  logic [LCNT_W-1:0]       b_cnt_inc;
  logic                    b_wr;
  logic signed [ACC_W-1:0] sum;
  logic                    res_row_last;

  // ---------------------------------------------------------------- handshakes
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign cfg_hit     = cfg_wr && (cfg_index_i == CFG_ROWS_A || cfg_index_i == CFG_INNER_DIM
                                  || cfg_index_i == CFG_COLS_B);

  assign in_acc  = in_valid_i & in_ready_o;
  assign b_acc   = in_acc && (in_data_i.kind == KIND_B);
  assign a_acc   = in_acc && (in_data_i.kind == KIND_A) && b_ready_q;
  assign err_acc = in_acc && (in_data_i.kind == KIND_A) && !b_ready_q;

  assign b_total    = nk_q * nc_q;
  assign inner_last = ({1'b0, inner_q} + CNT_W'(1)) >= nk_q;
  assign row_last_flag = ({1'b0, row_q} + CNT_W'(1)) >= nr_q;
  assign mac_last   = (j_q + CNT_W'(1)) >= nc_q;

  // A restarted load writes entry 0
  assign b_idx     = b_ready_q ? '0 : b_cnt_q;
  assign b_cnt_inc = b_idx + LCNT_W'(1);
  assign b_wr      = b_acc && (b_idx < LCNT_W'(STORE_DEPTH));

  // ------------------------------------------------------------- state machine
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (a_acc) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = emit_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (j_q == nc_q && !rd_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mac_issue  = 1'b0;
    emit_issue = 1'b0;
    take       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
      end
      ST_MAC: begin
        mac_issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        take       = rd_vld_q && (!out_valid_q || out_ready_i);
        emit_issue = (j_q < nc_q) && (!rd_vld_q || take);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------ config and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q       <= CNT_W'(1);
      nk_q       <= CNT_W'(1);
      nc_q       <= CNT_W'(1);
      b_cnt_q    <= '0;
      b_ready_q  <= 1'b0;
      inner_q    <= '0;
      row_q      <= '0;
      base_q     <= '0;
      emit_q     <= 1'b0;
      last_row_q <= 1'b0;
      first_q    <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_index_i)
        CFG_ROWS_A:    nr_q <= eff_dim(cfg_data_i);
        CFG_INNER_DIM: nk_q <= eff_dim(cfg_data_i);
        CFG_COLS_B:    nc_q <= eff_dim(cfg_data_i);
        default: begin
        end
      endcase
      b_cnt_q   <= '0;
      b_ready_q <= 1'b0;
      inner_q   <= '0;
      row_q     <= '0;
      base_q    <= '0;
    end else if (b_acc) begin
      b_cnt_q   <= b_cnt_inc;
      b_ready_q <= (2*CNT_W)'(b_cnt_inc) >= b_total;
      if (b_ready_q) begin
        inner_q <= '0;
        row_q   <= '0;
        base_q  <= '0;
      end
    end else if (a_acc) begin
      first_q <= (inner_q == '0);
      emit_q  <= inner_last;
      if (inner_last) begin
        inner_q    <= '0;
        base_q     <= '0;
        last_row_q <= row_last_flag;
        row_q      <= row_last_flag ? '0 : row_q + DIM_W'(1);
      end else begin
        inner_q <= inner_q + DIM_W'(1);
        base_q  <= base_q + ADDR_W'(nc_q);
      end
    end
  end

  // Column counter shared by the multiply pass and the readout
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (a_acc || (state_q == ST_DRAIN && state_d == ST_EMIT)) begin
      j_q <= '0;
    end else if (mac_issue || emit_issue) begin
      j_q <= j_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_acc) begin
      value_q <= in_data_i.value;
      addr_q  <= base_q;
    end else if (mac_issue) begin
      addr_q <= addr_q + ADDR_W'(1);
    end
  end

  // ----------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (b_wr) begin
      b_mem[b_idx[ADDR_W-1:0]] <= in_data_i.value;
    end
    if (mac_issue) begin
      b_rd_q <= b_mem[addr_q];
    end
  end

  assign sum = acc_s2_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_mem[s2_col_q] <= sum;
    end
    if (mac_issue || emit_issue) begin
      acc_rd_q <= acc_mem[j_q[DIM_W-1:0]];
      col_q    <= j_q[DIM_W-1:0];
    end
  end

  // ----------------------------------------------------- multiply-accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= mac_issue;
      s2_vld_q <= s1_vld_q;
      if (emit_issue) begin
        rd_vld_q <= 1'b1;
      end else if (take) begin
        rd_vld_q <= 1'b0;
      end
    end
  end

  // First element of a row starts from zero instead of the stale sum
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q   <= value_q * b_rd_q;
      acc_s2_q <= first_q ? '0 : acc_rd_q;
      s2_col_q <= col_q;
    end
  end

  // ------------------------------------------------------------ output stage
  assign res_row_last = ({1'b0, col_q} + CNT_W'(1)) == nc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (err_acc || take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_acc) begin
      out_q.result_value <= '0;
      out_q.column       <= '0;
      out_q.row_last     <= 1'b0;
      out_q.matrix_last  <= 1'b0;
      out_q.error        <= 1'b1;
    end else if (take) begin
      out_q.result_value <= acc_rd_q;
      out_q.column       <= COL_W'(col_q);
      out_q.row_last     <= res_row_last;
      out_q.matrix_last  <= res_row_last && last_row_q;
      out_q.error        <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------- assertions
`include "matrix_multiply_top_assert.svh"

  `MM_ASSERT_NOW(a_idle_quiet, in_ready_o, !s1_vld_q && !s2_vld_q && !rd_vld_q, "input taken while pipe busy")
  `MM_ASSERT_NOW(a_mac_b_loaded, state_q == ST_MAC, b_ready_q, "multiply pass without B loaded")
  `MM_ASSERT_NEXT(a_mac_to_drain, state_q == ST_MAC && mac_last, state_q == ST_DRAIN && s1_vld_q, "multiply pass did not end in drain")
  `MM_ASSERT_NOW(a_emit_bound, state_q == ST_EMIT, j_q <= nc_q, "readout ran past last column")
  `MM_ASSERT_NOW(a_last_flags, out_valid_o && out_data_o.matrix_last, out_data_o.row_last && !out_data_o.error, "matrix end without row end")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import mm_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 1000;
  localparam int MAX_REPORTS   = 40;
  localparam int RANDOM_ITEMS  = 280;

  typedef struct {
    in_t         word;
    int unsigned gap;
    bit          hold;
  } stim_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Words waiting to go in, and R elements the product should produce next
  stim_t word_q[$];
  out_t  r_elements_q[$];

  // Predictor state
  logic [CFG_W-1:0]        reg_rows  = CFG_W'(1);
  logic [CFG_W-1:0]        reg_inner = CFG_W'(1);
  logic [CFG_W-1:0]        reg_cols  = CFG_W'(1);
  logic signed [VAL_W-1:0] b_mem [STORE_DEPTH];
  longint                  row_sums [MAX_DIM];
  int                      b_words = 0;
  bit                      b_full  = 1'b0;
  int                      a_col   = 0;
  int                      a_row   = 0;

  int unsigned gap_left    = 0;
  bit          gap_armed   = 1'b0;
  int unsigned stall_left  = 0;
  int          quiet       = 0;
  int          fail_count  = 0;
  int          items_sent  = 0;
  bit          tx_calm     = 1'b0;
  bit          rx_calm     = 1'b0;
  bit          hold_next   = 1'b0;

  matrix_multiply_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int clamp_dim(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic void clear_product();
    b_words = 0;
    b_full  = 1'b0;
    a_col   = 0;
    a_row   = 0;
    for (int j = 0; j < MAX_DIM; j++) row_sums[j] = 0;
  endfunction

  // Fold one accepted word into the product and queue any R elements it completes
  function automatic void mac_word(in_t w);
    int                      nr;
    int                      nk;
    int                      nc;
    int                      j;
    bit                      last_row;
    out_t                    e;
    logic signed [VAL_W-1:0] av;
    nr = clamp_dim(reg_rows);
    nk = clamp_dim(reg_inner);
    nc = clamp_dim(reg_cols);
    av = w.value;
    if (w.kind == KIND_B) begin
      // a B word after a complete load starts a fresh one
      if (b_full) clear_product();
      if (b_words < STORE_DEPTH) b_mem[b_words] = av;
      b_words++;
      if (b_words >= nk * nc) b_full = 1'b1;
    end else if (!b_full) begin
      e = '0;
      e.error = 1'b1;
      r_elements_q.push_back(e);
    end else begin
      for (j = 0; j < nc; j++) begin
        row_sums[j] += longint'(av) * longint'(b_mem[a_col * nc + j]);
      end
      a_col++;
      if (a_col >= nk) begin
        last_row = (a_row + 1 >= nr);
        for (j = 0; j < nc; j++) begin
          e = '0;
          e.result_value = row_sums[j][ACC_W-1:0];
          e.column       = j[COL_W-1:0];
          e.row_last     = (j == nc - 1);
          e.matrix_last  = last_row && (j == nc - 1);
          r_elements_q.push_back(e);
          row_sums[j] = 0;
        end
        a_col = 0;
        a_row = last_row ? 0 : a_row + 1;
      end
    end
  endfunction

  function automatic void report(string field, logic [63:0] exp_v, logic [63:0] act_v);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
    end
  endfunction

  function automatic void check_element(out_t got);
    out_t want;
    if (r_elements_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: unexpected word, expected none actual %0h", $time, got);
      end
      return;
    end
    want = r_elements_q.pop_front();
    if (got.result_value !== want.result_value)
      report("result_value", 64'(want.result_value), 64'(got.result_value));
    if (got.column !== want.column) report("column", 64'(want.column), 64'(got.column));
    if (got.row_last !== want.row_last)
      report("row_last", 64'(want.row_last), 64'(got.row_last));
    if (got.matrix_last !== want.matrix_last)
      report("matrix_last", 64'(want.matrix_last), 64'(got.matrix_last));
    if (got.error !== want.error) report("error", 64'(want.error), 64'(got.error));
  endfunction

  // Input side: present queued words, honouring each word's gap and hold-off
  always @(posedge clk or negedge rst_n) begin : word_driver
    logic nv;
    in_t  nd;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      gap_left  = 0;
      gap_armed = 1'b0;
    end else begin
      nv = in_valid;
      nd = in_data;
      if (in_valid && in_ready) begin
        mac_word(in_data);
        nv = 1'b0;
      end
      if (!nv && word_q.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = word_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else if (!(word_q[0].hold && r_elements_q.size() != 0)) begin
          nd = word_q[0].word;
          void'(word_q.pop_front());
          nv = 1'b1;
          gap_armed = 1'b0;
        end
      end
      in_valid <= nv;
      in_data  <= nd;
    end
  end

  // Output side: take result words, with a random stall, possibly none, after each unless rx_calm
  always @(posedge clk or negedge rst_n) begin : result_monitor
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_element(out_data);
        stall_left = rx_calm ? 0 : $urandom_range(0, 3);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(MAX_DIM);
      2: return CFG_W'($urandom_range(MAX_DIM + 1, 31));
      3: return CFG_W'($urandom_range(4, 8));
      default: return CFG_W'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic push_word(logic kind, logic signed [VAL_W-1:0] v);
    stim_t s;
    s.word.kind  = kind;
    s.word.value = v;
    s.gap        = tx_calm ? 0 : $urandom_range(0, 3);
    s.hold       = hold_next;
    hold_next    = 1'b0;
    word_q.push_back(s);
    items_sent++;
  endtask

  task automatic push_random(logic kind, int n);
    for (int i = 0; i < n; i++) push_word(kind, pick_value());
  endtask

  // Wait until no word is pending or owed, then let the block drain
  task automatic settle();
    do begin
      while (word_q.size() != 0 || in_valid || r_elements_q.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (word_q.size() != 0 || in_valid || r_elements_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROWS_A:    reg_rows  = val;
      CFG_INNER_DIM: reg_inner = val;
      CFG_COLS_B:    reg_cols  = val;
      default: ;
    endcase
    clear_product();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
    settle();
    write_reg(CFG_ROWS_A, r);
    write_reg(CFG_INNER_DIM, k);
    write_reg(CFG_COLS_B, c);
  endtask

  // One setting: load B, stream whole A matrices, with some broken sequences mixed in
  task automatic run_phase(logic [CFG_W-1:0] r, logic [CFG_W-1:0] k, logic [CFG_W-1:0] c);
    int nb;
    int na;
    int part;
    int noise;
    configure(r, k, c);
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    nb = clamp_dim(k) * clamp_dim(c);
    na = clamp_dim(r) * clamp_dim(k);
    noise = $urandom_range(0, 5);
    if (noise == 0) push_random(KIND_A, 1);
    if (noise == 1 && nb > 1) begin
      part = $urandom_range(1, nb - 1);
      push_random(KIND_B, part);
      push_random(KIND_A, 1);
      push_random(KIND_B, nb - part);
    end else begin
      push_random(KIND_B, nb);
    end
    repeat ($urandom_range(1, 2)) begin
      hold_next = ($urandom_range(0, 4) == 0);
      push_random(KIND_A, na);
    end
    if (noise == 2) begin
      // reload over a loaded B, poke A mid-load, leave a part-done matrix behind
      push_random(KIND_B, 1);
      push_random(KIND_A, 1);
      push_random(KIND_B, nb - 1);
      push_random(KIND_A, $urandom_range(0, na - 1));
    end
  endtask

  initial begin : sequencer
    logic [CFG_W-1:0] r;
    logic [CFG_W-1:0] k;
    logic [CFG_W-1:0] c;
    clear_product();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset dimensions: A before any B, then 1x1 products at the extremes
    push_word(KIND_A, 16'sh1234);
    push_word(KIND_B, 16'sh8000);
    push_word(KIND_A, 16'sh8000);
    push_word(KIND_A, 16'sh7fff);

    // 2x2: full row, part row, reload mid-row with a pause, A during the reload
    configure(CFG_W'(2), CFG_W'(2), CFG_W'(2));
    push_word(KIND_B, 16'sh7fff);
    push_word(KIND_B, 16'sh8000);
    push_word(KIND_B, 16'shffff);
    push_word(KIND_B, 16'sh0001);
    push_word(KIND_A, 16'sh8000);
    push_word(KIND_A, 16'sh7fff);
    push_word(KIND_A, 16'sh0001);
    hold_next = 1'b1;
    push_word(KIND_B, 16'sh0007);
    push_word(KIND_A, 16'sh0005);
    push_word(KIND_B, 16'sh0003);
    push_word(KIND_B, 16'sh0004);
    push_word(KIND_B, 16'sh0005);
    push_word(KIND_A, 16'sh0001);
    push_word(KIND_A, 16'shffff);

    // Zero registers count as one
    configure('0, '0, '0);
    push_word(KIND_B, 16'sh00ff);
    push_word(KIND_A, 16'shff00);

    items_sent = 0;
    run_phase(CFG_W'(MAX_DIM), CFG_W'(1), CFG_W'(MAX_DIM));
    run_phase(CFG_W'(1), CFG_W'(MAX_DIM), CFG_W'(1));
    run_phase(CFG_W'(31), '0, CFG_W'(MAX_DIM + 1));
    while (items_sent < RANDOM_ITEMS) begin
      do begin
        r = pick_dim();
        k = pick_dim();
        c = pick_dim();
      end while (clamp_dim(k) * clamp_dim(c) > 48 || clamp_dim(r) * clamp_dim(k) > 48);
      run_phase(r, k, c);
    end

    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
